/* sv/i2da_pkg.sv */
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared constants and controller/datapath interface types for the 32-bit
// signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned NumDigits    = 10;
  localparam int unsigned BitsPerCycle = 4;
  localparam int unsigned ConvCycles   = ValueWidth / BitsPerCycle;
  localparam int unsigned CntWidth     = $clog2(ConvCycles);
  localparam int unsigned IdxWidth     = $clog2(NumDigits);

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;

  typedef logic [3:0] digit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new value and clear the digits
    logic shift;       // advance the binary-to-BCD conversion
    logic count;       // find the number of significant digits
    logic emit_sign;   // put out the minus sign
    logic emit_digit;  // put out the current digit and step down
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic negative;    // the captured value is below zero
    logic last_digit;  // the digit pointer stands on the units digit
  } sts_t;

endpackage

/* sv/i2da_ctrl.sv */
// ----------------------------------------------------------------------------
// i2da_ctrl
// Sequencer for the converter: conversion, digit count, sign and digit output.
// ----------------------------------------------------------------------------
module i2da_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  i2da_pkg::sts_t sts_i,
  output i2da_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import i2da_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StCount,
    StSign,
    StDigits
  } state_e;

  state_e              state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CntWidth'(ConvCycles - 1)) begin
          state_d = StCount;
        end
      end
      StCount: begin
        cmd_o.count = 1'b1;
        state_d     = sts_i.negative ? StSign : StDigits;
      end
      StSign: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = StDigits;
      end
      StDigits: begin
        cmd_o.emit_digit = 1'b1;
        if (sts_i.last_digit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

/* sv/i2da_dpath.sv */
// ----------------------------------------------------------------------------
// i2da_dpath
// Magnitude register, BCD digit registers with a four-bit-per-cycle
// shift-and-add-three converter, digit pointer and output registers.
// ----------------------------------------------------------------------------
module i2da_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [i2da_pkg::ValueWidth-1:0] value_i,
  input  i2da_pkg::cmd_t                    cmd_i,
  output i2da_pkg::sts_t                    sts_o,
  output logic                              strobe_o,
  output logic [7:0]                        character_o,
  output logic                              is_last_o,
  output logic [3:0]                        char_count_o
);
  import i2da_pkg::*;

  logic [ValueWidth-1:0] mag_q, mag_d;
  digit_t                digit_q [NumDigits];
  digit_t                digit_d [NumDigits];
  logic                  neg_q;
  logic [IdxWidth-1:0]   idx_q;
  logic [3:0]            total_q;
  logic [3:0]            ndig;
  logic                  strobe_q;
  logic [7:0]            char_q;
  logic                  last_q;
  logic [3:0]            count_q;
  logic [ValueWidth-1:0] load_mag;

  // Two's-complement magnitude; the most negative value maps to 2^31 exactly.
  assign load_mag = value_i[ValueWidth-1] ? (~value_i + 1'b1) : value_i;

  // Four shift-and-add-three steps per cycle.
  always_comb begin
    digit_t                tmp [NumDigits];
    logic [ValueWidth-1:0] m;
    m = mag_q;
    for (int i = 0; i < NumDigits; i++) begin
      tmp[i] = digit_q[i];
    end
    for (int b = 0; b < BitsPerCycle; b++) begin
      for (int i = 0; i < NumDigits; i++) begin
        if (tmp[i] >= 4'd5) begin
          tmp[i] = tmp[i] + 4'd3;
        end
      end
      for (int i = NumDigits - 1; i > 0; i--) begin
        tmp[i] = {tmp[i][2:0], tmp[i-1][3]};
      end
      tmp[0] = {tmp[0][2:0], m[ValueWidth-1]};
      m      = {m[ValueWidth-2:0], 1'b0};
    end
    for (int i = 0; i < NumDigits; i++) begin
      digit_d[i] = tmp[i];
    end
    mag_d = m;
  end

  // Number of significant digits, at least one.
  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < NumDigits; i++) begin
      if (digit_q[i] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= load_mag;
      neg_q <= value_i[ValueWidth-1];
      for (int i = 0; i < NumDigits; i++) begin
        digit_q[i] <= '0;
      end
    end else if (cmd_i.shift) begin
      mag_q <= mag_d;
      for (int i = 0; i < NumDigits; i++) begin
        digit_q[i] <= digit_d[i];
      end
    end
    if (cmd_i.count) begin
      idx_q   <= IdxWidth'(ndig - 4'd1);
      total_q <= ndig + {3'd0, neg_q};
    end else if (cmd_i.emit_digit) begin
      idx_q <= idx_q - 1'b1;
    end
  end

  // The last flag and the count are cleared in cycles without a character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      char_q   <= '0;
      last_q   <= 1'b0;
      count_q  <= '0;
    end else begin
      strobe_q <= cmd_i.emit_sign | cmd_i.emit_digit;
      if (cmd_i.emit_sign) begin
        char_q  <= AsciiMinus;
        last_q  <= 1'b0;
        count_q <= '0;
      end else if (cmd_i.emit_digit) begin
        char_q  <= AsciiZero + {4'd0, digit_q[idx_q]};
        last_q  <= (idx_q == '0);
        count_q <= (idx_q == '0) ? total_q : 4'd0;
      end else begin
        last_q  <= 1'b0;
        count_q <= '0;
      end
    end
  end

  assign sts_o.negative   = neg_q;
  assign sts_o.last_digit = (idx_q == '0);
  assign strobe_o         = strobe_q;
  assign character_o      = char_q;
  assign is_last_o        = last_q;
  assign char_count_o     = count_q;

endmodule

/* sv/int32_to_decimal_ascii_top.sv */
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_top
// Converts a signed 32-bit integer into its decimal ASCII text, one byte at a
// time, most significant digit first.
// ----------------------------------------------------------------------------
// Usage: drive value_i and raise start_i while busy_o is low; the word is
// taken at that clock edge. busy_o then stays high until the last character
// has been issued. Each output character is valid on character_o for exactly
// one cycle, marked by strobe_o. A negative value is led by a minus sign.
// is_last_o flags the final character of the run, and on that character
// char_count_o gives the run length (1 to 11); otherwise it reads zero.
// Sequence: after acceptance the conversion unit handles four input bits per
// cycle in a shift-and-add-three BCD converter, then finds the leading
// digit. Characters then leave at one per cycle through the output
// registers, and the next word can be taken in the cycle that the last
// character is shown. Reset returns the controller to idle and drops
// strobe_o; nothing is kept between words. The receiver cannot stall the
// output.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [i2da_pkg::ValueWidth-1:0] value_i,
  output logic                                  strobe_o,
  output logic [7:0]                            character_o,
  output logic                                  is_last_o,
  output logic [3:0]                            char_count_o
);
  import i2da_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences conversion, digit counting and output.
  i2da_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // The datapath holds the magnitude, the BCD digits and the output registers.
  i2da_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .strobe_o     (strobe_o),
    .character_o  (character_o),
    .is_last_o    (is_last_o),
    .char_count_o (char_count_o)
  );

`ifndef NO_ASSERTIONS
  // The last-character flag only appears together with a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni) is_last_o |-> strobe_o)
    else $error("is_last_o without strobe_o");

  // A run of characters is contiguous until its last character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !is_last_o) |=> strobe_o)
    else $error("character run broken before its last character");

  // The final character reports a length from one to eleven.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_last_o |-> (char_count_o >= 4'd1 && char_count_o <= 4'd11))
    else $error("character count out of range");

  // No character leaves in the cycle after a word is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !strobe_o)
    else $error("character issued right after acceptance");
`endif

endmodule

/* tb/sv/tb_int32_to_decimal_ascii_top.sv */
// ----------------------------------------------------------------------------
// tb_int32_to_decimal_ascii_top
// Self-checking bench for the signed 32-bit to decimal ASCII converter. Each
// accepted word is turned into its expected character run by an independent
// decimal renderer. Every strobed character is compared against the oldest
// entry of that run. The stimulus is a directed set of corner values
// followed by random words spread evenly over text lengths, driven under
// several sender idle profiles.
// ----------------------------------------------------------------------------
module tb_int32_to_decimal_ascii_top;
  import i2da_pkg::*;

  // Longest stretch without any handshake before the run is declared hung.
  // A sender gap is capped at MaxGap.
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxGap        = 60;
  // Quiet cycles after the last expected character.
  localparam int unsigned TailCycles    = 25;
  localparam int unsigned WordsPerPhase = 117;

  // One character of the decimal text as it appears on the result ports.
  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
    logic [3:0] char_count;
  } text_char_t;

  // Holds the characters still owed by the block, oldest first, and
  // compares each strobed character against the head of that list.
  class decimal_text_checker;
    text_char_t  owed_chars[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Renders the decimal text of an accepted word and queues it.
    function void note_word(logic [ValueWidth-1:0] word);
      logic [ValueWidth-1:0] magnitude;
      logic [3:0]            digits [NumDigits];
      int                    ndig;
      int                    j;
      text_char_t            c;

      // Two's-complement negation of 0x80000000 yields 2^31 as unsigned,
      // so the most negative value needs no special handling here.
      magnitude = word[ValueWidth-1] ? (~word + 1'b1) : word;
      ndig = 0;
      do begin
        digits[ndig] = 4'(magnitude % 10);
        magnitude    = magnitude / 10;
        ndig++;
      end while (magnitude != 0 && ndig < NumDigits);

      if (word[ValueWidth-1]) begin
        c.character  = AsciiMinus;
        c.is_last    = 1'b0;
        c.char_count = 4'd0;
        owed_chars.push_back(c);
      end
      for (j = ndig - 1; j >= 0; j--) begin
        c.character  = AsciiZero + 8'(digits[j]);
        c.is_last    = (j == 0);
        c.char_count = (j == 0) ? 4'(ndig + (word[ValueWidth-1] ? 1 : 0)) : 4'd0;
        owed_chars.push_back(c);
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_char(text_char_t got);
      text_char_t want;

      if (owed_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b count=%0d",
                                  got.character, got.is_last, got.char_count));
        return;
      end
      want = owed_chars.pop_front();
      if (got.character !== want.character)
        report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                  got.character, want.character));
      if (got.is_last !== want.is_last)
        report_mismatch($sformatf("is_last %0b, expected %0b", got.is_last, want.is_last));
      if (got.char_count !== want.char_count)
        report_mismatch($sformatf("char_count %0d, expected %0d",
                                  got.char_count, want.char_count));
    endtask

    function int unsigned pending();
      return owed_chars.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic signed [ValueWidth-1:0] value_i;
  logic                         strobe_o;
  logic [7:0]                   character_o;
  logic                         is_last_o;
  logic [3:0]                   char_count_o;

  decimal_text_checker text_chk = new();

  // Chance, in percent, that the sender stays idle for another cycle.
  int unsigned sender_idle_pct;

  int32_to_decimal_ascii_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .character_o  (character_o),
    .is_last_o    (is_last_o),
    .char_count_o (char_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are sampled on the rising edge. Inputs only move on the
  // falling edge, so the values seen here are the ones the block samples.
  always @(posedge clk_i) begin : monitor
    text_char_t seen;
    if (rst_ni) begin
      if (start_i && !busy_o) text_chk.note_word(value_i);
      if (strobe_o) begin
        seen.character  = character_o;
        seen.is_last    = is_last_o;
        seen.char_count = char_count_o;
        text_chk.check_char(seen);
      end
    end
  end

  // Any accepted word or character restarts the count of quiet cycles.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || strobe_o) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Keeps start low for a random number of cycles. While idle, the value
  // port carries noise that the block must not pick up.
  task automatic idle_sender();
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < sender_idle_pct) begin
      start_i = 1'b0;
      value_i = $urandom();
      @(negedge clk_i);
      gap++;
    end
  endtask

  // Presents one word and holds it until the block takes it. Start is left
  // high on return, so back-to-back words keep it high without a dip.
  task automatic send_word(input logic [ValueWidth-1:0] word);
    idle_sender();
    value_i = word;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every owed character has come out.
  task automatic wait_text_drained();
    start_i = 1'b0;
    while (text_chk.pending() != 0) @(negedge clk_i);
  endtask

  // Random word whose text length is spread evenly from 1 to 10 digits,
  // with a share of full-range words and of values on a power of ten.
  function automatic logic [ValueWidth-1:0] random_word();
    int unsigned       kind;
    int unsigned       ndig;
    longint unsigned   low_mag;
    longint unsigned   span;
    longint unsigned   magnitude;

    kind = $urandom_range(9);
    if (kind < 3) return $urandom();
    ndig    = $urandom_range(1, NumDigits);
    low_mag = 1;
    repeat (ndig - 1) low_mag *= 10;
    if (kind == 3) begin
      // Either 10^k or 10^k - 1, where the digit count changes.
      magnitude = low_mag - $urandom_range(1);
    end else begin
      span      = (ndig == NumDigits) ? 64'd2147483649 - low_mag : 9 * low_mag;
      magnitude = low_mag + ({$urandom(), $urandom()} % span);
    end
    if ($urandom_range(1)) return ValueWidth'(64'd0 - magnitude);
    if (magnitude > 64'd2147483647) magnitude = 64'd2147483647;
    return ValueWidth'(magnitude);
  endfunction

  // Corner words: zero, single digits, changes of text length at 10, 100
  // and 10^9, both extremes, the most negative value, and patterns that
  // toggle every input bit.
  logic signed [ValueWidth-1:0] corner_words [] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
    32'sd100, 32'sd12345, 32'sd999999999, 32'sd1000000000, -32'sd1000000000,
    32'sd2147483647, -32'sd2147483647, 32'sh8000_0000, 32'sh5555_5555,
    32'shAAAA_AAAA, 32'sd1073741824, -32'sd1234567890
  };

  // Sender idle profiles of the random phases. The receiver cannot stall
  // this block, so only the sender side varies.
  int unsigned phase_idle_pct [3] = '{84, 0, 33};

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    value_i         = '0;
    sender_idle_pct = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corner words, back to back.
    foreach (corner_words[i]) send_word(corner_words[i]);
    // The sender waits here until the whole text of the corners is out.
    wait_text_drained();

    foreach (phase_idle_pct[p]) begin
      sender_idle_pct = phase_idle_pct[p];
      repeat (WordsPerPhase) send_word(random_word());
      wait_text_drained();
    end

    // Any character strobed after the last expected one is flagged by the
    // monitor during this tail.
    repeat (TailCycles) @(negedge clk_i);
    if (text_chk.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
